// File: hw/rtl/ftcs_pkg.sv
package ftcs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_WIDTH  = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POT_G  = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cen_re;
    logic signed [SAMPLE_W-1:0] cen_im;
    logic signed [SAMPLE_W-1:0] cen_v;
    logic signed [SAMPLE_W-1:0] west_re;
    logic signed [SAMPLE_W-1:0] west_im;
    logic signed [SAMPLE_W-1:0] east_re;
    logic signed [SAMPLE_W-1:0] east_im;
    logic signed [SAMPLE_W-1:0] north_re;
    logic signed [SAMPLE_W-1:0] north_im;
    logic signed [SAMPLE_W-1:0] south_re;
    logic signed [SAMPLE_W-1:0] south_im;
    logic                       last;
  } ftcs_job_t;

endpackage

// File: hw/rtl/ftcs_front.sv
module ftcs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ftcs_pkg::WIDTH_W-1:0]   width_cfg,
  input  logic [ftcs_pkg::HEIGHT_W-1:0]  height_cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_phi_re,
  input  logic signed [15:0]             in_phi_im,
  input  logic signed [15:0]             in_potential,
  input  logic                           in_drain,
  output logic                           job_valid,
  input  logic                           job_ready,
  output ftcs_pkg::ftcs_job_t            job
);
  import ftcs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [9:0] col_r;
  logic [12:0] row_r;
  logic [9:0] c_r;
  logic [12:0] r_r;
  logic [10:0] w_r;
  logic [12:0] h_r;
  logic [47:0] cen_mem [0:MAX_WIDTH-1];
  logic [31:0] nor_mem [0:MAX_WIDTH-1];
  logic [47:0] cen_rd_r, east_rd_r;
  logic [31:0] nor_rd_r;
  logic [47:0] west_r;
  logic [47:0] s_r;
  logic [9:0]  clr_r;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [9:0]  c_eff;
  logic [12:0] r_eff;
  logic [9:0]  c_east;
  ftcs_job_t   job_r;
  logic        jv_r, jv_nxt;
  logic [47:0] cen_use, east_use;
  logic [31:0] nor_use;

  always_comb begin
    w_eff = width_cfg;
    if (w_eff == 11'd0) w_eff = 11'd1;
    if (w_eff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    h_eff = height_cfg;
    if (h_eff == 13'd0) h_eff = 13'd1;
    if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    c_eff = ({1'b0, col_r} >= w_eff) ? 10'(w_eff - 11'd1) : col_r;
    r_eff = (row_r > h_eff) ? h_eff : row_r;
    c_east = c_r + 10'd1;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign job_valid = jv_r;
  assign job = job_r;

  assign cen_use  = cen_rd_r;
  assign east_use = ({1'b0, c_r} + 11'd1 < w_r) ? east_rd_r : 48'd0;
  assign nor_use  = (r_r >= 13'd2) ? nor_rd_r : 32'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_CALC;
      ST_CALC: state_nxt = (r_r >= 13'd1) ? ST_PUSH : ST_IDLE;
      ST_PUSH: if (!jv_r || job_ready) state_nxt = ST_IDLE;
      ST_CLR:  if (clr_r == 10'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    jv_nxt = jv_r;
    if (jv_r && job_ready) jv_nxt = 1'b0;
    if (state_r == ST_PUSH && (!jv_r || job_ready)) jv_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      col_r <= '0;
      row_r <= '0;
      jv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      jv_r <= jv_nxt;
      case (state_r)
        ST_CLR: begin
          cen_mem[clr_r] <= '0;
          nor_mem[clr_r] <= '0;
          clr_r <= clr_r + 10'd1;
        end
        ST_IDLE: begin
          if (in_valid) begin
            c_r <= c_eff;
            r_r <= r_eff;
            w_r <= w_eff;
            h_r <= h_eff;
            s_r <= (in_drain || r_eff == h_eff) ? 48'd0 :
                   {in_phi_re, in_phi_im, in_potential};
            if ({1'b0, c_eff} + 11'd1 >= w_eff) begin
              col_r <= '0;
              row_r <= (r_eff + 13'd1 > h_eff) ? 13'd0 : r_eff + 13'd1;
            end else begin
              col_r <= c_eff + 10'd1;
            end
          end
        end
        ST_RD: begin
          cen_rd_r <= cen_mem[c_r];
          east_rd_r <= cen_mem[c_east];
          nor_rd_r <= nor_mem[c_r];
        end
        ST_CALC: begin
          nor_mem[c_r] <= cen_use[47:16];
          cen_mem[c_r] <= s_r;
        end
        ST_PUSH: begin
          if (!jv_r || job_ready) begin
            job_r.cen_re <= cen_use[47:32];
            job_r.cen_im <= cen_use[31:16];
            job_r.cen_v <= cen_use[15:0];
            job_r.west_re <= (c_r != 10'd0) ? west_r[47:32] : 16'd0;
            job_r.west_im <= (c_r != 10'd0) ? west_r[31:16] : 16'd0;
            job_r.east_re <= east_use[47:32];
            job_r.east_im <= east_use[31:16];
            job_r.north_re <= nor_use[31:16];
            job_r.north_im <= nor_use[15:0];
            job_r.south_re <= s_r[47:32];
            job_r.south_im <= s_r[31:16];
            job_r.last <= (r_r == h_r) && ({1'b0, c_r} + 11'd1 == w_r);
            west_r <= cen_use;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hw/rtl/ftcs_back.sv
module ftcs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [ftcs_pkg::COEF_W-1:0] coef_x,
  input  logic signed [ftcs_pkg::COEF_W-1:0] coef_y,
  input  logic signed [ftcs_pkg::COEF_W-1:0] pot_gain,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  ftcs_pkg::ftcs_job_t               job,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_new_re,
  output logic signed [15:0]                out_new_im,
  output logic                              out_last_in_frame
);
  import ftcs_pkg::*;

  logic        s1_v_r, s2_v_r, o_v_r;
  ftcs_job_t   j_r;
  logic signed [18:0] lxr, lyr, lxi, lyi;
  logic signed [37:0] pxr_r, pyr_r, pxi_r, pyi_r;
  logic signed [31:0] vr_r, vi_r;
  logic signed [50:0] gr_r, gi_r;
  logic signed [53:0] dr, di;
  logic signed [23:0] qr, qi;
  logic signed [24:0] nr, ni;
  logic        last1_r, last2_r;
  logic signed [15:0] cre1_r, cim1_r, cre2_r, cim2_r;
  logic signed [38:0] lapr_r, lapi_r;
  logic        adv2, adv1, adv0;

  assign adv2 = !o_v_r || out_ready;
  assign adv1 = !s2_v_r || adv2;
  assign adv0 = !s1_v_r || adv1;
  assign job_ready = adv0;

  always_comb begin
    lxr = 19'(j_r.east_re) + 19'(j_r.west_re) - (19'(j_r.cen_re) <<< 1);
    lyr = 19'(j_r.north_re) + 19'(j_r.south_re) - (19'(j_r.cen_re) <<< 1);
    lxi = 19'(j_r.east_im) + 19'(j_r.west_im) - (19'(j_r.cen_im) <<< 1);
    lyi = 19'(j_r.north_im) + 19'(j_r.south_im) - (19'(j_r.cen_im) <<< 1);
    dr = (54'(lapr_r) <<< 14) - 54'(gr_r) + (54'sd1 <<< 29);
    di = (54'(lapi_r) <<< 14) - 54'(gi_r) + (54'sd1 <<< 29);
    qr = 24'(dr >>> 30);
    qi = 24'(di >>> 30);
    nr = 25'(cre2_r) - 25'(qi);
    ni = 25'(cim2_r) + 25'(qr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv0) begin
        s1_v_r <= job_valid;
        if (job_valid) j_r <= job;
      end
      if (adv1) begin
        s2_v_r <= s1_v_r;
        pxr_r <= coef_x * lxr;
        pyr_r <= coef_y * lyr;
        pxi_r <= coef_x * lxi;
        pyi_r <= coef_y * lyi;
        vr_r <= j_r.cen_v * j_r.cen_re;
        vi_r <= j_r.cen_v * j_r.cen_im;
        cre1_r <= j_r.cen_re;
        cim1_r <= j_r.cen_im;
        last1_r <= j_r.last;
      end
      if (adv2) begin
        o_v_r <= s2_v_r;
        lapr_r <= 39'(pxr_r) + 39'(pyr_r);
        lapi_r <= 39'(pxi_r) + 39'(pyi_r);
        gr_r <= pot_gain * vr_r;
        gi_r <= pot_gain * vi_r;
        cre2_r <= cre1_r;
        cim2_r <= cim1_r;
        last2_r <= last1_r;
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_new_re = (nr > 25'sd32767) ? 16'sh7fff : (nr < -25'sd32768) ? 16'sh8000 : nr[15:0];
  assign out_new_im = (ni > 25'sd32767) ? 16'sh7fff : (ni < -25'sd32768) ? 16'sh8000 : ni[15:0];
  assign out_last_in_frame = last2_r;
endmodule

// File: hw/rtl/ftcs_schrodinger_stencil_2d_top.sv
// channel | ports                                         | direction
// in      | in_valid/in_ready, phi_re/im, potential, drain | sink
// out     | out_valid/out_ready, new_re/im, last_in_frame  | source
// cfg     | cfg_we, cfg_index, cfg_data                    | sink
// An item passes through the front in order: transfer, line buffer read, update, hand-off;
// items of the first grid row yield no result and skip the hand-off.
// The back is a 3-stage multiply pipeline. The front takes a new item only once idle.
// Reset is synchronous, active low; the line buffers are then cleared, all 1024 entries,
// with in_ready low.
// Back-pressure on out stalls the back, then the hand-off, then in_ready.
module ftcs_schrodinger_stencil_2d_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [ftcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftcs_pkg::CFG_W-1:0]     cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_phi_re,
  input  logic signed [15:0] in_phi_im,
  input  logic signed [15:0] in_potential,
  input  logic        in_drain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_new_re,
  output logic signed [15:0] out_new_im,
  output logic        out_last_in_frame
);
  import ftcs_pkg::*;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic signed [COEF_W-1:0] cx_r, cy_r, pg_r;
  logic job_valid, job_ready;
  ftcs_job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd1024;
      height_r <= 13'd1024;
      cx_r <= '0;
      cy_r <= '0;
      pg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        REG_COEF_X: cx_r <= cfg_data;
        REG_COEF_Y: cy_r <= cfg_data;
        REG_POT_G:  pg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ftcs_front u_front (
    .clk, .rst_n, .width_cfg(width_r), .height_cfg(height_r),
    .in_valid, .in_ready, .in_phi_re, .in_phi_im, .in_potential, .in_drain,
    .job_valid, .job_ready, .job
  );

  ftcs_back u_back (
    .clk, .rst_n, .coef_x(cx_r), .coef_y(cy_r), .pot_gain(pg_r),
    .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_new_re, .out_new_im, .out_last_in_frame
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("front overlap");
`endif
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ftcs_pkg::*;

  localparam int MAXW = MAX_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic signed [15:0] v;
  } point_t;

  typedef struct {
    logic signed [15:0] new_re;
    logic signed [15:0] new_im;
    logic               last;
  } update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_phi_re = '0;
  logic signed [15:0] in_phi_im = '0;
  logic signed [15:0] in_potential = '0;
  logic in_drain = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_new_re;
  logic signed [15:0] out_new_im;
  logic out_last_in_frame;

  ftcs_schrodinger_stencil_2d_top u_top (.*);

  always #5 clk = ~clk;

  int grid_w = 1024;
  int grid_h = 1024;
  logic signed [17:0] cx = '0, cy = '0, gain = '0;
  point_t north_row [MAXW];
  point_t center_row [MAXW];
  point_t west_pt;
  int col = 0, row = 0;

  update_t pending_updates[$];
  int errors = 0;
  int updates_seen = 0;
  int burst_left = 0;

  function automatic longint step_delta(longint c, longint w, longint e, longint n,
                                        longint s, longint v);
    longint lap;
    lap = (longint'(cx) * (e + w - 2 * c) + longint'(cy) * (n + s - 2 * c)) * 16384;
    return lap - longint'(gain) * (v * c);
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return x[15:0];
  endfunction

  function automatic void predict_update(point_t p, logic drn);
    point_t s, cen, e, w, n, z;
    longint dre, dim;
    int c, r;
    update_t u;
    z = '{default: '0};
    if (col >= grid_w) col = grid_w - 1;
    if (row > grid_h) row = grid_h;
    c = col;
    r = row;
    s = (drn || r == grid_h) ? z : p;
    if (r >= 1) begin
      cen = center_row[c];
      e = (c + 1 < grid_w) ? center_row[c + 1] : z;
      w = (c > 0) ? west_pt : z;
      n = (r >= 2) ? north_row[c] : z;
      dre = step_delta(longint'(cen.re), longint'(w.re), longint'(e.re), longint'(n.re),
                       longint'(s.re), longint'(cen.v));
      dim = step_delta(longint'(cen.im), longint'(w.im), longint'(e.im), longint'(n.im),
                       longint'(s.im), longint'(cen.v));
      dre = (dre + (64'sd1 <<< 29)) >>> 30;
      dim = (dim + (64'sd1 <<< 29)) >>> 30;
      u.new_re = clip16(longint'(cen.re) - dim);
      u.new_im = clip16(longint'(cen.im) + dre);
      u.last = (r == grid_h && c + 1 == grid_w);
      pending_updates.push_back(u);
      west_pt = cen;
    end
    north_row[c] = center_row[c];
    center_row[c] = s;
    if (c + 1 >= grid_w) begin
      col = 0;
      row = (r + 1 > grid_h) ? 0 : r + 1;
    end else begin
      col = c + 1;
    end
  endfunction

  task automatic send_point(logic signed [15:0] re, logic signed [15:0] im,
                            logic signed [15:0] v, logic drn);
    point_t p;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_phi_re <= re;
    in_phi_im <= im;
    in_potential <= v;
    in_drain <= drn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = '{re, im, v};
    predict_update(p, drn);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    int wv, hv;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    wv = int'(val[10:0]);
    hv = int'(val[12:0]);
    case (idx)
      REG_WIDTH:  grid_w = (wv < 1) ? 1 : ((wv > MAXW) ? MAXW : wv);
      REG_HEIGHT: grid_h = (hv < 1) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : hv);
      REG_COEF_X: cx = val;
      REG_COEF_Y: cy = val;
      REG_POT_G:  gain = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (pending_updates.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(int w, int h, int kx, int ky, int g);
    wait_idle();
    write_reg(REG_WIDTH, 18'(w));
    write_reg(REG_HEIGHT, 18'(h));
    write_reg(REG_COEF_X, 18'(kx));
    write_reg(REG_COEF_Y, 18'(ky));
    write_reg(REG_POT_G, 18'(g));
  endtask

  task automatic run_frame(int mode);
    logic signed [15:0] re, im, v;
    for (int r = 0; r <= grid_h; r++) begin
      for (int c = 0; c < grid_w; c++) begin
        case (mode)
          0: begin
            re = 16'sh7fff; im = -16'sh8000; v = 16'sh7fff;
          end
          1: begin
            re = -16'sh8000; im = 16'sh7fff; v = -16'sh8000;
          end
          default: begin
            re = 16'($urandom); im = 16'($urandom); v = 16'($urandom);
          end
        endcase
        if (r == grid_h) send_point(16'($urandom), 16'($urandom), 16'($urandom),
                                    1'($urandom_range(0, 1)));
        else send_point(re, im, v, (mode > 1) && ($urandom_range(0, 15) == 0));
      end
    end
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic test_extremes();
    setup(3, 2, 131071, -131072, 131071);
    run_frame(0);
    setup(1, 1, -131072, 131071, -131072);
    run_frame(1);
    setup(4, 2, 0, 0, 0);
    run_frame(2);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 300) begin
      setup($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 262143),
            $urandom_range(0, 262143), $urandom_range(0, 262143));
      sent += grid_w * (grid_h + 1);
      run_frame(2);
    end
  endtask

  task automatic test_wide_frame();
    setup(256, 1, $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191));
    run_frame(2);
    setup(1, 200, 4096, 4096, 4096);
    run_frame(2);
  endtask

  task automatic test_odd_registers();
    setup(0, 0, 17, 17, 17);
    run_frame(2);
    setup(2047, 5, 17, 17, 17);
    write_reg(REG_WIDTH, 18'd5);
    write_reg(REG_UNUSED, 18'h3ffff);
    run_frame(2);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(0, 99) < 70) || (updates_seen % 64 < 16);
  end

  always @(posedge clk) begin
    update_t u;
    if (rst_n && out_valid && out_ready) begin
      updates_seen++;
      if (pending_updates.size() == 0) begin
        $error("unexpected transfer: re %0d im %0d", out_new_re, out_new_im);
        errors++;
      end else begin
        u = pending_updates.pop_front();
        if (out_new_re !== u.new_re) begin
          $error("new_re expected %0d actual %0d", u.new_re, out_new_re);
          errors++;
        end
        if (out_new_im !== u.new_im) begin
          $error("new_im expected %0d actual %0d", u.new_im, out_new_im);
          errors++;
        end
        if (out_last_in_frame !== u.last) begin
          $error("last_in_frame expected %0d actual %0d", u.last, out_last_in_frame);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (north_row[i]) begin
      north_row[i] = '{default: '0};
      center_row[i] = '{default: '0};
    end
    west_pt = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_odd_registers();
    test_random_frames();
    test_wide_frame();
    wait_idle();
    $display("covered extreme values, clamped registers, wide and tall frames, random grids");
    $display("%0d updates checked, %0d left over", updates_seen, pending_updates.size());
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
